[rtl/mdh_pkg.sv]
// Shared types, constants and round tables for the message-ID MD5 hasher.
package mdh_pkg;

  localparam logic [7:0] AT_CHAR = 8'h40;

  // Expected lower-case letters at byte indexes 1 to 10
  function automatic logic [7:0] pm_char(input logic [3:0] idx);
    logic [7:0] r;
    begin
      case (idx)
        4'd0: r = 8'h70;
        4'd1: r = 8'h6f;
        4'd2: r = 8'h73;
        4'd3: r = 8'h74;
        4'd4: r = 8'h6d;
        4'd5: r = 8'h61;
        4'd6: r = 8'h73;
        4'd7: r = 8'h74;
        4'd8: r = 8'h65;
        4'd9: r = 8'h72;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    begin
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    end
  endfunction

  function automatic logic [31:0] md_k(input logic [5:0] i);
    logic [31:0] r;
    begin
      case (i)
        6'd0: r = 32'hd76aa478;  6'd1: r = 32'he8c7b756;  6'd2: r = 32'h242070db;
        6'd3: r = 32'hc1bdceee;  6'd4: r = 32'hf57c0faf;  6'd5: r = 32'h4787c62a;
        6'd6: r = 32'ha8304613;  6'd7: r = 32'hfd469501;  6'd8: r = 32'h698098d8;
        6'd9: r = 32'h8b44f7af;  6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
        6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
        6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
        6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
        6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
        6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
        6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
        6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
        6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
        6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
        6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
        6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
        6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
        6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
        6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
        6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
        6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
        6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
        default: r = 32'heb86d391;
      endcase
      return r;
    end
  endfunction

  function automatic logic [4:0] md_r(input logic [5:0] i);
    logic [4:0] r;
    begin
      case ({i[5:4], i[1:0]})
        4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
        4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
        4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
        4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
    end
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIX, ST_RND, ST_ADD, ST_PAD, ST_LEN, ST_OUT
  } state_t;

  // Byte source selection for buffer writes
  typedef enum logic [1:0] {
    WS_DATA, WS_PAD80, WS_ZERO, WS_LEN
  } wsel_t;

  // Controller to datapath
  typedef struct packed {
    logic       take;      // absorb the accepted byte
    logic       wr;        // write one buffer byte at wr_pos
    wsel_t      wsel;
    logic [5:0] wr_pos;
    logic       fix;       // fold one byte of the local part (index fix_idx)
    logic [3:0] fix_idx;
    logic       rnd;       // run one MD5 round
    logic [5:0] rnd_idx;
    logic       rnd_start; // load working regs from chain
    logic       add;       // fold working regs into chain
    logic       restart;   // load initial chain, clear counters
    logic       load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       do_fix;    // this byte triggers local-part fold
    logic       block_end; // this byte fills the block
    logic [5:0] pos;       // current fill position
  } stat_t;

endpackage

[rtl/mdh_if.sv]
// Valid/ready channel carrying one word of payload.
interface mdh_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/mdh_ctrl.sv]
// Controller sequencing byte intake, local-part folding, rounds and padding.
module mdh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_last,
  input  logic          in_nobyte,
  output logic          out_valid,
  input  logic          out_ready,
  input  mdh_pkg::stat_t st,
  output mdh_pkg::cmd_t  cmd
);
  import mdh_pkg::*;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       fin, fin_next;     // finishing after this compress
  logic       lenblk, lenblk_next; // current compress is the length block
  logic       padded, padded_next; // 0x80 already written for this identifier
  logic       ovalid, ovalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      fin <= 1'b0;
      lenblk <= 1'b0;
      padded <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      fin <= fin_next;
      lenblk <= lenblk_next;
      padded <= padded_next;
      ovalid <= ovalid_next;
    end
  end

  assign out_valid = ovalid;

  // Next state and commands
  always_comb begin
    logic acc;
    logic tk;
    state_next = state;
    cnt_next = cnt;
    fin_next = fin;
    lenblk_next = lenblk;
    padded_next = padded;
    ovalid_next = ovalid && !out_ready;
    cmd = '0;
    cmd.wsel = WS_DATA;
    in_ready = 1'b0;
    acc = 1'b0;
    tk = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        acc = in_valid && in_ready;
        tk = acc && !in_nobyte;
        cmd.take = tk;
        cmd.wr = tk;
        cmd.wr_pos = st.pos;
        fin_next = acc && in_last;
        lenblk_next = 1'b0;
        padded_next = 1'b0;
        if (tk && st.do_fix) begin
          state_next = ST_FIX;
          cnt_next = 6'd1;
        end else if (tk && st.block_end) begin
          state_next = ST_RND;
          cnt_next = '0;
        end else if (acc && in_last) begin
          state_next = ST_PAD;
          cnt_next = tk ? st.pos + 6'd1 : st.pos;
        end
      end
      ST_FIX: begin
        cmd.fix = 1'b1;
        cmd.fix_idx = cnt[3:0];
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd10) begin
          state_next = fin ? ST_PAD : ST_IDLE;
          cnt_next = 6'd12;
        end
      end
      ST_RND: begin
        cmd.rnd = 1'b1;
        cmd.rnd_idx = cnt;
        cmd.rnd_start = (cnt == 6'd0);
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        cnt_next = '0;
        if (lenblk) state_next = ST_OUT;
        else if (padded) begin
          // pad spilled over: zero fill a fresh block that carries the length
          state_next = ST_LEN;
          lenblk_next = 1'b1;
        end else if (fin) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_PAD: begin
        // cnt holds the byte position where 0x80 goes
        cmd.wr = 1'b1;
        cmd.wr_pos = cnt;
        cmd.wsel = WS_PAD80;
        state_next = ST_LEN;
        cnt_next = cnt + 6'd1;
        padded_next = 1'b1;
        lenblk_next = (cnt <= 6'd55);
        if (cnt == 6'd63) begin
          state_next = ST_RND;
          cnt_next = '0;
        end
      end
      ST_LEN: begin
        // zero fill, and length in last eight bytes of the length block
        cmd.wr = 1'b1;
        cmd.wr_pos = cnt;
        cnt_next = cnt + 6'd1;
        cmd.wsel = (lenblk && cnt >= 6'd56) ? WS_LEN : WS_ZERO;
        if (cnt == 6'd63) begin
          state_next = ST_RND;
          cnt_next = '0;
        end
      end
      ST_OUT: begin
        // hold until the previous digest has left
        if (!ovalid || out_ready) begin
          cmd.load_out = 1'b1;
          cmd.restart = 1'b1;
          ovalid_next = 1'b1;
          state_next = ST_IDLE;
          fin_next = 1'b0;
          lenblk_next = 1'b0;
          padded_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/mdh_dp.sv]
// Datapath: block buffer, folding state, byte counter, MD5 round unit and chain.
module mdh_dp (
  input  logic           clk,
  input  logic           rst,
  input  mdh_pkg::cmd_t  cmd,
  input  logic [7:0]     data_byte,
  output mdh_pkg::stat_t st,
  output logic [63:0]    digest_low,
  output logic [63:0]    digest_high
);
  import mdh_pkg::*;

  // Block buffer as sixteen little-endian message words
  logic [31:0] buf_mem [16];
  logic [31:0] ch_a, ch_b, ch_c, ch_d;
  logic [31:0] wa, wb, wc, wd;
  logic [63:0] byte_count;
  logic        at_seen, local_match;
  logic [7:0]  wbyte, tbyte, fbyte;
  logic [63:0] bits;
  logic [3:0]  g;
  logic [31:0] f, m, sum, rot;
  logic [5:0]  pos;

  function automatic logic [31:0] f0(input logic [31:0] b, c, d);
    return (b & c) | (~b & d);
  endfunction

  assign pos = byte_count[5:0];
  assign bits = {byte_count[60:0], 3'b000};

  // Byte after folding rules; local-part match check
  always_comb begin
    tbyte = at_seen ? fold(data_byte) : data_byte;
    st.do_fix = !at_seen && data_byte == AT_CHAR && byte_count == 64'd11 && local_match;
    st.block_end = pos == 6'd63;
    st.pos = pos;
  end

  always_comb begin
    case (cmd.wsel)
      WS_DATA:  wbyte = tbyte;
      WS_PAD80: wbyte = 8'h80;
      WS_ZERO:  wbyte = 8'h00;
      default:  wbyte = bits[{cmd.wr_pos[2:0], 3'b000} +: 8];
    endcase
  end

  // Round message word and function
  always_comb begin
    logic [5:0] i;
    i = cmd.rnd_idx;
    case (i[5:4])
      2'd0: begin f = (wb & wc) | (~wb & wd); g = i[3:0]; end
      2'd1: begin f = (wd & wb) | (~wd & wc); g = i[3:0] * 4'd5 + 4'd1; end
      2'd2: begin f = wb ^ wc ^ wd;           g = i[3:0] * 4'd3 + 4'd5; end
      default: begin f = wc ^ (wb | ~wd);     g = i[3:0] * 4'd7; end
    endcase
    m = buf_mem[g];
    sum = wa + f + md_k(i) + m;
    rot = (sum << md_r(i)) | (sum >> (6'd32 - {1'b0, md_r(i)}));
  end

  assign fbyte = fold(buf_mem[{2'b00, cmd.fix_idx[3:2]}][{cmd.fix_idx[1:0], 3'b000} +: 8]);

  // Buffer writes, one byte lane at a time
  always_ff @(posedge clk) begin
    if (cmd.wr) buf_mem[cmd.wr_pos[5:2]][{cmd.wr_pos[1:0], 3'b000} +: 8] <= wbyte;
    if (cmd.fix) buf_mem[{2'b00, cmd.fix_idx[3:2]}][{cmd.fix_idx[1:0], 3'b000} +: 8] <= fbyte;
  end

  // Folding state and counter
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      byte_count <= '0;
      at_seen <= 1'b0;
      local_match <= 1'b1;
    end else if (cmd.take) begin
      byte_count <= byte_count + 64'd1;
      if (!at_seen) begin
        if (data_byte == AT_CHAR) at_seen <= 1'b1;
        else if (byte_count >= 64'd1 && byte_count <= 64'd10) begin
          if (fold(data_byte) != pm_char(byte_count[3:0] - 4'd1)) local_match <= 1'b0;
        end else if (byte_count >= 64'd11) local_match <= 1'b0;
      end
    end
  end

  // Chain and working registers
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      ch_a <= 32'h67452301;
      ch_b <= 32'hefcdab89;
      ch_c <= 32'h98badcfe;
      ch_d <= 32'h10325476;
    end else if (cmd.add) begin
      ch_a <= ch_a + wa;
      ch_b <= ch_b + wb;
      ch_c <= ch_c + wc;
      ch_d <= ch_d + wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      if (cmd.rnd_start) begin
        wa <= ch_d;
        wd <= ch_c;
        wc <= ch_b;
        wb <= ch_b + ((ch_a + f0(ch_b, ch_c, ch_d) + 32'hd76aa478 + m) << 7
                      | (ch_a + f0(ch_b, ch_c, ch_d) + 32'hd76aa478 + m) >> 25);
      end else begin
        wa <= wd;
        wd <= wc;
        wc <= wb;
        wb <= wb + rot;
      end
    end
    if (cmd.load_out) begin
      digest_low <= {ch_b, ch_a};
      digest_high <= {ch_d, ch_c};
    end
  end

endmodule

[rtl/message_id_md5_hasher.sv]
// Top level of the message-ID MD5 hasher.
// Usage: each input word carries one identifier byte (data_byte), a last mark,
// and no_byte (word with no byte, e.g. an empty identifier ending in last).
// After the first '@' bytes are folded to lower case; a "postmaster" local
// part followed by '@' at index 11 has bytes 1 to 10 folded as well.
// On the word with last, one result word is sent with the 128-bit digest,
// byte 0 in digest_low[7:0].
// Rate: one plain byte per cycle while the controller is idle. Each full
// 64-byte block stalls input for the 64 rounds of the single round unit plus
// the chain add; the postmaster fix also stalls input while bytes 1 to 10 are
// folded. Finishing writes the pad and length bytes one per cycle (up to 72
// writes) and runs one or two compressions before the result is sent.
// Reset clears control, the chain and the counters; the buffer is not cleared.
// A stalled result holds in the output register while input goes on; the
// next identifier's finish waits for it to leave before loading its digest.
module message_id_md5_hasher (
  input logic clk,
  input logic rst,
  mdh_if.sink   in_ch,
  mdh_if.source out_ch
);
  import mdh_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic [63:0] dl, dh;

  mdh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_last(in_ch.data[8]), .in_nobyte(in_ch.data[9]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .st(st), .cmd(cmd)
  );

  mdh_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(in_ch.data[7:0]),
    .st(st), .digest_low(dl), .digest_high(dh)
  );

  assign out_ch.data = {dh, dl};
endmodule

[tb/tb.sv]
// Testbench for message_id_md5_hasher: directed and random identifiers checked against an MD5 predictor.
module tb;
  import mdh_pkg::*;

  typedef struct {
    logic [7:0]   b;
    bit           lst;
    bit           nob;
    bit           has;    // digest typed in by hand
    logic [127:0] dig;
  } word_t;

  localparam logic [127:0] DIG_EMPTY = {64'h7e42f8ec980980e9, 64'h04b2008fd98c1dd4};
  localparam logic [127:0] DIG_A     = {64'h61267769e299c331, 64'ha8b6f1c0b975c10c};
  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;

  logic clk = 0;
  logic rst = 1;

  mdh_if #(10)  in_ch (clk);
  mdh_if #(128) out_ch (clk);

  message_id_md5_hasher uut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Predictor state
  logic [31:0] sine_k [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  int rot_amt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
  logic [7:0]  local_word [10] = '{"p", "o", "s", "t", "m", "a", "s", "t", "e", "r"};

  logic [7:0]  msg_blk [64];
  logic [31:0] chain [4];
  logic [63:0] byte_cnt;
  bit          at_found;
  bit          pm_ok;

  word_t        pres_q [$];
  logic [127:0] digest_q [$];
  int           errs = 0;
  int           cycles = 0;
  bit           long_hold = 0;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void digest_restart();
    chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    byte_cnt = 0;
    at_found = 0;
    pm_ok = 1;
  endfunction

  function automatic void digest_compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, s;
    int g, r;
    for (int i = 0; i < 16; i++)
      m[i] = {msg_blk[4*i+3], msg_blk[4*i+2], msg_blk[4*i+1], msg_blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      r = rot_amt[(i / 16) * 4 + i % 4];
      s = a + f + sine_k[i] + m[g];
      t = d; d = c; c = b;
      b = b + ((s << r) | (s >> (32 - r)));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  // Absorb one identifier word; return the digest on the last word
  function automatic bit digest_step(input logic [7:0] cin, input bit lst, input bit nob,
                                     output logic [127:0] dg);
    logic [7:0]  c;
    logic [63:0] n, bits;
    int pos;
    c = cin;
    if (!nob) begin
      n = byte_cnt;
      pos = n[5:0];
      if (at_found) begin
        c = lower(c);
      end else if (c == AT_CHAR) begin
        at_found = 1;
        if (n == 11 && pm_ok)
          for (int i = 1; i <= 10; i++) msg_blk[i] = lower(msg_blk[i]);
      end else if (n >= 1 && n <= 10) begin
        if (lower(c) != local_word[n-1]) pm_ok = 0;
      end else if (n >= 11) begin
        pm_ok = 0;
      end
      msg_blk[pos] = c;
      byte_cnt = n + 1;
      if (pos == 63) digest_compress();
    end
    if (!lst) return 0;
    bits = byte_cnt << 3;
    pos = byte_cnt[5:0];
    msg_blk[pos++] = 8'h80;
    if (pos > 56) begin
      while (pos < 64) msg_blk[pos++] = 8'h00;
      digest_compress();
      pos = 0;
    end
    while (pos < 56) msg_blk[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) msg_blk[56+i] = bits[8*i +: 8];
    digest_compress();
    dg = {chain[3], chain[2], chain[1], chain[0]};
    digest_restart();
    return 1;
  endfunction

  // Predict on each accepted input word, check each accepted digest
  logic [127:0] pred_dig, want_dig;
  word_t        acc_w;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        acc_w = pres_q.pop_front();
        if (digest_step(in_ch.data[7:0], in_ch.data[8], in_ch.data[9], pred_dig))
          digest_q.push_back(acc_w.has ? acc_w.dig : pred_dig);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected digest %h", out_ch.data);
        end else begin
          want_dig = digest_q.pop_front();
          if (out_ch.data[63:0] !== want_dig[63:0] || out_ch.data[127:64] !== want_dig[127:64]) begin
            errs++;
            if (errs <= 10)
              $display("digest mismatch: low exp %h got %h, high exp %h got %h",
                       want_dig[63:0], out_ch.data[63:0], want_dig[127:64], out_ch.data[127:64]);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: stall on a pattern, with one long hold-off on request
  initial begin
    int mode, left;
    out_ch.ready <= 0;
    mode = 0;
    left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_ch.ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 400);
      end
      left--;
      case (mode)
        0: out_ch.ready <= 1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (left % 7 == 0);
        default: out_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
      @(posedge clk);
    end
  end

  // Stimulus build
  word_t stim_q [$];
  bit    drain_at [int];
  int    hold_at;

  function automatic logic [7:0] rand_byte();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return 8'(("A" + $urandom_range(0, 25)));
    if (k < 5) return 8'(("a" + $urandom_range(0, 25)));
    if (k == 5) return AT_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    if ($urandom_range(0, 29) == 0)
      stim_q.push_back('{8'($urandom_range(0, 255)), 0, 1, 0, '0});
    stim_q.push_back('{b, 0, 0, 0, '0});
  endfunction

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    return $urandom_range(0, 1) ? c - 8'd32 : c;
  endfunction

  function automatic void add_identifier();
    int kind, len;
    kind = $urandom_range(0, 9);
    len = 0;
    if (kind <= 3) begin
      // postmaster local part, sometimes broken by one letter or a shifted '@'
      int bad;
      bad = (kind == 3) ? $urandom_range(0, 11) : -1;
      add_byte(rand_byte());
      for (int i = 0; i < 10; i++)
        if (i == bad) add_byte(8'($urandom_range(0, 255)));
        else if (!(bad == 10 && i == 9)) add_byte(rand_case(local_word[i]));
      if (bad == 11) add_byte("x");
      add_byte(AT_CHAR);
      len = $urandom_range(0, 40);
    end else if (kind <= 6) begin
      repeat ($urandom_range(0, 15)) add_byte(rand_byte());
      add_byte(AT_CHAR);
      len = $urandom_range(0, 50);
    end else if (kind == 7) begin
      len = $urandom_range(0, 80);
    end else if (kind == 8) begin
      len = $urandom_range(100, 140);
    end
    repeat (len) add_byte(rand_byte());
    if (stim_q.size() > 0 && !stim_q[$].nob && $urandom_range(0, 3) != 0 && kind != 9)
      stim_q[$].lst = 1;
    else
      stim_q.push_back('{8'($urandom_range(0, 255)), 1, 1, 0, '0});
  endfunction

  // Sender: bursts of random length with random gaps
  initial begin
    word_t dir_tab [23];
    word_t w;
    int burst, msgs;
    dir_tab = '{
      '{8'h00, 1, 1, 1, DIG_EMPTY},   // empty identifier
      '{8'h5a, 0, 1, 0, '0},          // word without byte, ignored
      '{8'h61, 1, 0, 1, DIG_A},       // "a"
      '{8'hff, 1, 0, 0, '0},
      '{8'h00, 1, 0, 0, '0},
      '{"x", 0, 0, 0, '0}, '{"P", 0, 0, 0, '0}, '{"o", 0, 0, 0, '0}, '{"s", 0, 0, 0, '0},
      '{"t", 0, 0, 0, '0}, '{"M", 0, 0, 0, '0}, '{"a", 0, 0, 0, '0}, '{"S", 0, 0, 0, '0},
      '{"T", 0, 0, 0, '0}, '{"E", 0, 0, 0, '0}, '{"R", 0, 0, 0, '0}, '{"@", 0, 0, 0, '0},
      '{"Q", 1, 0, 0, '0},            // postmaster local part folded
      '{"A", 0, 0, 0, '0}, '{"@", 0, 0, 0, '0}, '{"B", 0, 0, 0, '0},
      '{8'h00, 1, 1, 0, '0},          // last without byte
      '{"@", 1, 0, 0, '0}
    };
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    drain_at[stim_q.size()] = 1;
    msgs = 0;
    hold_at = -1;
    while (stim_q.size() < 830) begin
      add_identifier();
      msgs++;
      if (msgs == 6) hold_at = stim_q.size();
      if (msgs % 12 == 0) drain_at[stim_q.size()] = 1;
    end

    digest_restart();
    in_ch.valid <= 0;
    in_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    burst = 0;
    for (int idx = 0; idx < stim_q.size(); idx++) begin
      // pause until every digest has come back
      if (drain_at.exists(idx)) begin
        in_ch.valid <= 0;
        @(posedge clk);
        while (digest_q.size() != 0) @(posedge clk);
      end
      if (idx == hold_at) long_hold = 1;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) begin
          in_ch.valid <= 0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      burst--;
      w = stim_q[idx];
      pres_q.push_back(w);
      in_ch.valid <= 1;
      in_ch.data <= {w.nob, w.lst, w.b};
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errs == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
